@@ src/ble_midi_packet_parser_macros.svh @@
// Assertion macros shared by the BLE MIDI packet parser RTL.
// Needs nothing else; include by bare file name inside a module body.
`ifndef BLE_MIDI_PACKET_PARSER_MACROS_SVH
`define BLE_MIDI_PACKET_PARSER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, quiet in reset
`define BMPP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, quiet in reset
`define BMPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/bmpp_pkg.sv @@
// Shared types and constants of the BLE MIDI packet parser.
// No dependencies; used by the decoder and the top level.
package bmpp_pkg;

    // Byte classes
    localparam logic [7:0] REALTIME_MIN = 8'hF8;
    localparam logic [3:0] NIB_PROG_CHANGE = 4'hC;
    localparam logic [3:0] NIB_CHAN_PRESSURE = 4'hD;

    // Message lengths
    localparam logic [1:0] LEN_ONE = 2'd1;
    localparam logic [1:0] LEN_TWO = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    // Parse phase, one-hot
    typedef enum logic [3:0] {
        PH_TOP          = 4'b0001,
        PH_AFTER_TS     = 4'b0010,
        PH_AFTER_STATUS = 4'b0100,
        PH_AWAIT_SECOND = 4'b1000
    } bmpp_phase_t;

    typedef struct packed {
        logic [7:0]  current_status;
        bmpp_phase_t parse_phase;
        logic [7:0]  held_data;
    } bmpp_state_t;

    typedef struct packed {
        logic [7:0] midi_status;
        logic [7:0] first_data;
        logic [7:0] second_data;
        logic [1:0] message_length;
    } bmpp_msg_t;

    // Outcome of decoding one byte
    typedef struct packed {
        bmpp_state_t next_state;
        logic        emit;
        bmpp_msg_t   msg;
    } bmpp_step_t;

endpackage

@@ src/bmpp_in_if.sv @@
// Byte channel into the BLE MIDI packet parser.
// No dependencies.
interface bmpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       first_of_packet;
    logic       last_of_packet;

    modport source (output valid, output packet_byte, output first_of_packet,
                    output last_of_packet, input ready);
    modport sink (input valid, input packet_byte, input first_of_packet,
                  input last_of_packet, output ready);
endinterface

@@ src/bmpp_out_if.sv @@
// MIDI message channel out of the BLE MIDI packet parser.
// No dependencies.
interface bmpp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] midi_status;
    logic [7:0] first_data;
    logic [7:0] second_data;
    logic [1:0] message_length;

    modport source (output valid, output midi_status, output first_data,
                    output second_data, output message_length, input ready);
    modport sink (input valid, input midi_status, input first_data,
                  input second_data, input message_length, output ready);
endinterface

@@ src/bmpp_decode.sv @@
// Combinational byte decoder: running status, phase and message assembly.
// Depends on bmpp_pkg.
module bmpp_decode (
    input  bmpp_pkg::bmpp_state_t cur,
    input  logic [7:0]            packet_byte,
    input  logic                  first_of_packet,
    input  logic                  last_of_packet,
    output bmpp_pkg::bmpp_step_t  step
);
    import bmpp_pkg::*;

    bmpp_phase_t phase_eff;
    logic        do_top;
    logic        do_take;
    logic        is_realtime;

    assign is_realtime = (packet_byte >= REALTIME_MIN);

    // Walk the byte through the phase logic
    always_comb
    begin
        step            = '0;
        step.next_state = cur;
        do_top          = 1'b0;
        do_take         = 1'b0;
        phase_eff       = first_of_packet ? PH_TOP : cur.parse_phase;

        if (first_of_packet && (last_of_packet || packet_byte[7]))
        begin
            // drop one-byte packets and the header byte
            step.next_state.parse_phase = PH_TOP;
        end
        else
        begin
            case (phase_eff)
                PH_TOP:
                begin
                    do_top = 1'b1;
                end
                PH_AFTER_TS:
                begin
                    if (is_realtime)
                    begin
                        step.next_state.parse_phase = PH_TOP;
                        step.emit = 1'b1;
                        step.msg  = '{packet_byte, 8'h00, 8'h00, LEN_ONE};
                    end
                    else if (packet_byte[7])
                    begin
                        step.next_state.current_status = packet_byte;
                        step.next_state.parse_phase    = PH_AFTER_STATUS;
                    end
                    else
                    begin
                        do_take = 1'b1;
                    end
                end
                PH_AFTER_STATUS:
                begin
                    do_take = 1'b1;
                end
                PH_AWAIT_SECOND:
                begin
                    step.next_state.parse_phase = PH_TOP;
                    if (packet_byte[7])
                    begin
                        // drop the partial message, handle the byte afresh
                        do_top = 1'b1;
                    end
                    else
                    begin
                        step.emit = 1'b1;
                        step.msg  = '{cur.current_status, cur.held_data, packet_byte,
                                      LEN_THREE};
                    end
                end
                default:
                begin
                    step.next_state.parse_phase = PH_TOP;
                end
            endcase

            // Timestamp, realtime or data where a timestamp may stand
            if (do_top)
            begin
                if (is_realtime)
                begin
                    step.next_state.parse_phase = PH_TOP;
                    step.emit = 1'b1;
                    step.msg  = '{packet_byte, 8'h00, 8'h00, LEN_ONE};
                end
                else if (packet_byte[7])
                begin
                    step.next_state.parse_phase = PH_AFTER_TS;
                end
                else
                begin
                    do_take = 1'b1;
                end
            end

            // First data byte of a message of the running status
            if (do_take)
            begin
                if (!cur.current_status[7])
                begin
                    step.next_state.parse_phase = PH_TOP;
                end
                else if (cur.current_status[7:4] inside {NIB_PROG_CHANGE,
                                                         NIB_CHAN_PRESSURE})
                begin
                    step.next_state.parse_phase = PH_TOP;
                    step.emit = 1'b1;
                    step.msg  = '{cur.current_status, packet_byte, 8'h00, LEN_TWO};
                end
                else
                begin
                    step.next_state.held_data   = packet_byte;
                    step.next_state.parse_phase = PH_AWAIT_SECOND;
                end
            end
        end

        // A packet end discards any partial message
        if (last_of_packet)
        begin
            step.next_state.parse_phase = PH_TOP;
        end
    end

endmodule

@@ src/ble_midi_packet_parser.sv @@
// Top level of the BLE MIDI packet parser: input register, decoder, result register.
// Depends on bmpp_pkg, bmpp_in_if, bmpp_out_if, bmpp_decode and the macros header.
//
//  Channel | Dir | Payload                                                  | Handshake
//  pkt     | in  | packet_byte[8], first_of_packet, last_of_packet           | valid/ready
//  msg     | out | midi_status[8], first_data[8], second_data[8], length[2]  | valid/ready
//
// One byte a cycle when no result stalls; a result is registered from the held byte.
// The byte register feeds the decoder, whose state update sets the rate.
// A byte is taken while a result waits, as long as the byte register is free.
// Reset (rst_n low, asynchronous) clears the running status, phase and both valids.
// A stalled result holds the byte register only when that byte also yields a result.
module ble_midi_packet_parser (
    input logic       clk,
    input logic       rst_n,
    bmpp_in_if.sink   pkt,
    bmpp_out_if.source msg
);
    import bmpp_pkg::*;

    `include "ble_midi_packet_parser_macros.svh"

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_first_reg;
    logic        in_last_reg;
    bmpp_state_t state_reg;
    logic        out_valid_reg;
    bmpp_msg_t   out_msg_reg;

    bmpp_step_t  step;
    logic        out_free;
    logic        advance;
    logic        take;

    // Decode the held byte against the current state
    bmpp_decode u_decode (
        .cur             (state_reg),
        .packet_byte     (in_byte_reg),
        .first_of_packet (in_first_reg),
        .last_of_packet  (in_last_reg),
        .step            (step)
    );

    // Handshake control
    assign out_free  = !out_valid_reg || msg.ready;
    assign advance   = in_valid_reg && (!step.emit || out_free);
    assign pkt.ready = !in_valid_reg || advance;
    assign take      = pkt.valid && pkt.ready;

    // Hold the incoming byte valid until the decoder consumes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Capture the byte on each transfer
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg  <= pkt.packet_byte;
            in_first_reg <= pkt.first_of_packet;
            in_last_reg  <= pkt.last_of_packet;
        end
    end

    // Advance the parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{8'h00, PH_TOP, 8'h00};
        end
        else if (advance)
        begin
            state_reg <= step.next_state;
        end
    end

    // Result valid: set on emit, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && step.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (msg.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance && step.emit)
        begin
            out_msg_reg <= step.msg;
        end
    end

    assign msg.valid          = out_valid_reg;
    assign msg.midi_status    = out_msg_reg.midi_status;
    assign msg.first_data     = out_msg_reg.first_data;
    assign msg.second_data    = out_msg_reg.second_data;
    assign msg.message_length = out_msg_reg.message_length;

    // Checks
    `BMPP_ASSERT_IMPL(a_len_nonzero, clk, rst_n, out_valid_reg, out_msg_reg.message_length != 2'd0, "result with zero length")
    `BMPP_ASSERT_IMPL(a_rt_alone, clk, rst_n, out_valid_reg && (out_msg_reg.message_length == LEN_ONE), (out_msg_reg.midi_status >= REALTIME_MIN) && (out_msg_reg.first_data == 8'h00) && (out_msg_reg.second_data == 8'h00), "one-byte result is not a bare realtime byte")
    `BMPP_ASSERT_NEXT(a_byte_kept, clk, rst_n, in_valid_reg && !advance, in_valid_reg && $stable(in_byte_reg), "stalled byte lost")
    `BMPP_ASSERT_NEXT(a_end_resets_phase, clk, rst_n, advance && in_last_reg, state_reg.parse_phase == PH_TOP, "phase not cleared at packet end")
    `BMPP_ASSERT_NEXT(a_result_kept, clk, rst_n, out_valid_reg && !msg.ready, out_valid_reg && $stable(out_msg_reg), "stalled result overwritten")

endmodule
